// ===== rtl/t16alu_pkg.sv =====
`timescale 1ns / 1ps

package t16alu_pkg;

  // shift types as coded in the instruction
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // result selection in the back end
  typedef enum logic [3:0] {
    OP_PASS,
    OP_ADD,
    OP_SHIFT,
    OP_AND,
    OP_EOR,
    OP_ORR,
    OP_BIC,
    OP_MVN,
    OP_MUL
  } op_sel_t;

  // which flags an instruction writes
  typedef enum logic [1:0] {
    FL_NONE,
    FL_NZ,
    FL_NZC,
    FL_NZCV
  } fl_t;

  // adder carry-in source
  typedef enum logic [1:0] {
    CIN_ZERO,
    CIN_ONE,
    CIN_FLAG
  } cin_t;

  // decoded instruction passed from front to back
  typedef struct packed {
    op_sel_t     op;
    logic [1:0]  sh_type;
    logic        amt_reg;
    logic [2:0]  ra;
    logic [2:0]  rb;
    logic        a_inv;
    logic        b_imm;
    logic        b_inv;
    cin_t        cin;
    logic [31:0] imm;
    logic [2:0]  dest;
    logic        wr;
    fl_t         fl;
    logic        nh;
  } uop_t;

  // one result item
  typedef struct packed {
    logic [2:0]  dest_index;
    logic [31:0] dest_value;
    logic        reg_written;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        not_handled;
  } res_t;

endpackage

// ===== rtl/thumb16_alu_execute.sv =====
`timescale 1ns / 1ps

// Thumb 16-bit data-processing execute unit with eight low registers and nzcv.
// Input channel: push/full. An item is taken at a clock edge with push high and
// full low; func selects executing the instruction halfword or loading
// load_value into register load_index.
// Result channel: empty/pop. The oldest result sits on the result ports while
// empty is low and leaves at an edge with pop high; every item gives one result.
// Path: an item goes from the decode queue to the operand read, then executes
// into the result queue, from which it can be popped.
// Throughput: one item per cycle unless the result queue is full; operands are
// read from the register file ahead of execute and the write of the item just
// before is bypassed, so dependent instructions follow back to back.
// The decode queue lets the front keep taking items while the execute stage
// waits on a full result queue; when the receiver stalls, both queues fill and
// full rises after CMD_DEPTH + RES_DEPTH + 1 items are held.
// Reset (rst, synchronous) empties both queues and clears registers and flags
// to zero.
module thumb16_alu_execute #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [15:0] instruction,
  input  logic        in_it_block,
  input  logic [2:0]  load_index,
  input  logic [31:0] load_value,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  dest_index,
  output logic [31:0] dest_value,
  output logic        reg_written,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_c,
  output logic        flag_v,
  output logic        not_handled
);

  import t16alu_pkg::*;

  uop_t dec_uop;
  uop_t q_uop;
  logic q_valid;
  logic q_take;
  logic cmd_push;
  logic res_full;
  logic res_push;
  logic res_valid;
  res_t ex_res;
  res_t res_head;

  // front: classify the item
  t16alu_decode u_decode (
    .func        (func),
    .instruction (instruction),
    .in_it_block (in_it_block),
    .load_index  (load_index),
    .load_value  (load_value),
    .uop         (dec_uop)
  );

  assign cmd_push = push && !full;

  // queue between front and back
  t16alu_fifo #(
    .WIDTH ($bits(uop_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (dec_uop),
    .full  (full),
    .pop   (q_take),
    .dout  (q_uop),
    .valid (q_valid)
  );

  // back: registers, flags and alu
  t16alu_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_uop   (q_uop),
    .in_take  (q_take),
    .out_full (res_full),
    .out_push (res_push),
    .out_res  (ex_res)
  );

  // result queue
  t16alu_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (ex_res),
    .full  (res_full),
    .pop   (pop && res_valid),
    .dout  (res_head),
    .valid (res_valid)
  );

  assign empty       = !res_valid;
  assign dest_index  = res_head.dest_index;
  assign dest_value  = res_head.dest_value;
  assign reg_written = res_head.reg_written;
  assign flag_n      = res_head.flag_n;
  assign flag_z      = res_head.flag_z;
  assign flag_c      = res_head.flag_c;
  assign flag_v      = res_head.flag_v;
  assign not_handled = res_head.not_handled;

endmodule

// ===== rtl/t16alu_fifo.sv =====
`timescale 1ns / 1ps

module t16alu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("item pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("item popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/t16alu_decode.sv =====
`timescale 1ns / 1ps

module t16alu_decode (
  input  logic               func,
  input  logic [15:0]        instruction,
  input  logic               in_it_block,
  input  logic [2:0]         load_index,
  input  logic [31:0]        load_value,
  output t16alu_pkg::uop_t   uop
);

  import t16alu_pkg::*;

  // group and opcode codes
  localparam logic [2:0] GRP_ADDSUB = 3'b011;
  localparam logic [5:0] PFX_ALU    = 6'b010000;
  localparam logic [1:0] IMM_MOV    = 2'd0;
  localparam logic [1:0] IMM_CMP    = 2'd1;
  localparam logic [1:0] IMM_ADD    = 2'd2;
  localparam logic [1:0] IMM_SUB    = 2'd3;
  localparam logic [3:0] ALU_AND    = 4'h0;
  localparam logic [3:0] ALU_EOR    = 4'h1;
  localparam logic [3:0] ALU_LSL    = 4'h2;
  localparam logic [3:0] ALU_LSR    = 4'h3;
  localparam logic [3:0] ALU_ASR    = 4'h4;
  localparam logic [3:0] ALU_ADC    = 4'h5;
  localparam logic [3:0] ALU_SBC    = 4'h6;
  localparam logic [3:0] ALU_ROR    = 4'h7;
  localparam logic [3:0] ALU_TST    = 4'h8;
  localparam logic [3:0] ALU_RSB    = 4'h9;
  localparam logic [3:0] ALU_CMP    = 4'hA;
  localparam logic [3:0] ALU_CMN    = 4'hB;
  localparam logic [3:0] ALU_ORR    = 4'hC;
  localparam logic [3:0] ALU_MUL    = 4'hD;
  localparam logic [3:0] ALU_BIC    = 4'hE;
  localparam logic [3:0] ALU_MVN    = 4'hF;

  uop_t       u;
  logic       force_fl;
  logic [4:0] imm5;

  assign imm5 = instruction[10:6];

  // classify the item and set up the back end controls
  always_comb begin
    u          = '0;
    u.op       = OP_PASS;
    u.fl       = FL_NONE;
    u.cin      = CIN_ZERO;
    u.sh_type  = SH_LSL;
    force_fl   = 1'b0;
    if (func) begin
      u.b_imm = 1'b1;
      u.imm   = load_value;
      u.dest  = load_index;
      u.wr    = 1'b1;
    end else if (instruction[15:14] == 2'b00) begin
      if (instruction[13]) begin
        // imm8 forms
        u.ra    = instruction[10:8];
        u.dest  = instruction[10:8];
        u.b_imm = 1'b1;
        u.imm   = {24'd0, instruction[7:0]};
        u.wr    = 1'b1;
        u.fl    = FL_NZCV;
        u.op    = OP_ADD;
        case (instruction[12:11])
          IMM_MOV: begin
            u.op = OP_PASS;
            u.fl = FL_NZ;
          end
          IMM_CMP: begin
            u.b_inv  = 1'b1;
            u.cin    = CIN_ONE;
            u.wr     = 1'b0;
            force_fl = 1'b1;
          end
          IMM_ADD: begin
            u.cin = CIN_ZERO;
          end
          IMM_SUB: begin
            u.b_inv = 1'b1;
            u.cin   = CIN_ONE;
          end
          default: begin
            u.op = OP_PASS;
          end
        endcase
      end else if (instruction[13:11] == GRP_ADDSUB) begin
        // three-register and imm3 add/sub
        u.op    = OP_ADD;
        u.ra    = instruction[5:3];
        u.rb    = instruction[8:6];
        u.b_imm = instruction[10];
        u.imm   = {29'd0, instruction[8:6]};
        u.b_inv = instruction[9];
        u.cin   = instruction[9] ? CIN_ONE : CIN_ZERO;
        u.dest  = instruction[2:0];
        u.wr    = 1'b1;
        u.fl    = FL_NZCV;
      end else begin
        // shift by immediate, zero means 32 for right shifts
        u.op      = OP_SHIFT;
        u.sh_type = instruction[12:11];
        u.ra      = instruction[5:3];
        u.imm     = (instruction[12:11] != SH_LSL && imm5 == 5'd0) ? 32'd32 :
                    {27'd0, imm5};
        u.dest    = instruction[2:0];
        u.wr      = 1'b1;
        u.fl      = FL_NZC;
      end
    end else if (instruction[15:10] == PFX_ALU) begin
      // register alu ops
      u.ra   = instruction[2:0];
      u.rb   = instruction[5:3];
      u.dest = instruction[2:0];
      u.wr   = 1'b1;
      u.fl   = FL_NZC;
      case (instruction[9:6])
        ALU_AND: u.op = OP_AND;
        ALU_EOR: u.op = OP_EOR;
        ALU_LSL: begin
          u.op      = OP_SHIFT;
          u.sh_type = SH_LSL;
          u.amt_reg = 1'b1;
        end
        ALU_LSR: begin
          u.op      = OP_SHIFT;
          u.sh_type = SH_LSR;
          u.amt_reg = 1'b1;
        end
        ALU_ASR: begin
          u.op      = OP_SHIFT;
          u.sh_type = SH_ASR;
          u.amt_reg = 1'b1;
        end
        ALU_ADC: begin
          u.op  = OP_ADD;
          u.cin = CIN_FLAG;
          u.fl  = FL_NZCV;
        end
        ALU_SBC: begin
          u.op    = OP_ADD;
          u.b_inv = 1'b1;
          u.cin   = CIN_FLAG;
          u.fl    = FL_NZCV;
        end
        ALU_ROR: begin
          u.op      = OP_SHIFT;
          u.sh_type = SH_ROR;
          u.amt_reg = 1'b1;
        end
        ALU_TST: begin
          u.op     = OP_AND;
          u.wr     = 1'b0;
          force_fl = 1'b1;
        end
        ALU_RSB: begin
          u.op    = OP_ADD;
          u.a_inv = 1'b1;
          u.b_imm = 1'b1;
          u.cin   = CIN_ONE;
          u.fl    = FL_NZCV;
        end
        ALU_CMP: begin
          u.op     = OP_ADD;
          u.b_inv  = 1'b1;
          u.cin    = CIN_ONE;
          u.fl     = FL_NZCV;
          u.wr     = 1'b0;
          force_fl = 1'b1;
        end
        ALU_CMN: begin
          u.op     = OP_ADD;
          u.fl     = FL_NZCV;
          u.wr     = 1'b0;
          force_fl = 1'b1;
        end
        ALU_ORR: u.op = OP_ORR;
        ALU_MUL: begin
          u.op = OP_MUL;
          u.fl = FL_NZ;
        end
        ALU_BIC: u.op = OP_BIC;
        ALU_MVN: u.op = OP_MVN;
        default: u.op = OP_MVN;
      endcase
    end else begin
      u.nh = 1'b1;
    end
    // inside an it block only compares and tests touch the flags
    if (in_it_block && !func && !force_fl) begin
      u.fl = FL_NONE;
    end
  end

  assign uop = u;

endmodule

// ===== rtl/t16alu_exec.sv =====
`timescale 1ns / 1ps

module t16alu_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  t16alu_pkg::uop_t   in_uop,
  output logic               in_take,
  input  logic               out_full,
  output logic               out_push,
  output t16alu_pkg::res_t   out_res
);

  import t16alu_pkg::*;

  logic        busy;
  uop_t        cur;
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic        fwd_valid;
  logic [2:0]  fwd_idx;
  logic [31:0] fwd_val;
  logic [3:0]  nzcv;
  logic [7:0]  reg_ok;
  logic [31:0] regs [8];

  logic        advance;
  logic [31:0] a_val;
  logic [31:0] b_val;
  logic [31:0] op_a;
  logic [31:0] b_raw;
  logic [31:0] op_b;
  logic        cin;
  logic [32:0] sum;
  logic        add_v;
  logic [7:0]  sh_amt;
  logic [32:0] sh_out;
  logic [31:0] product;
  logic [31:0] result;
  logic        c_out;
  logic        v_out;
  logic [3:0]  nzcv_next;

  // shift with carry out, amount 0 to 255
  function automatic logic [32:0] shift_c(input logic [31:0] x, input logic [1:0] kind,
                                          input logic [7:0] amt, input logic ci);
    logic [32:0] t;
    logic [31:0] r;
    logic        co;
    begin
      t  = '0;
      r  = x;
      co = ci;
      if (amt != 8'd0) begin
        case (kind)
          SH_LSL: begin
            if (amt < 8'd32) begin
              t  = {1'b0, x} << amt[4:0];
              r  = t[31:0];
              co = t[32];
            end else begin
              r  = '0;
              co = (amt == 8'd32) ? x[0] : 1'b0;
            end
          end
          SH_LSR: begin
            if (amt < 8'd32) begin
              t  = {x, 1'b0} >> amt[4:0];
              r  = t[32:1];
              co = t[0];
            end else begin
              r  = '0;
              co = (amt == 8'd32) ? x[31] : 1'b0;
            end
          end
          SH_ASR: begin
            if (amt < 8'd32) begin
              t  = 33'($signed({x, 1'b0}) >>> amt[4:0]);
              r  = t[32:1];
              co = t[0];
            end else begin
              r  = {32{x[31]}};
              co = x[31];
            end
          end
          default: begin
            r  = (x >> amt[4:0]) | (x << (6'd32 - {1'b0, amt[4:0]}));
            co = r[31];
          end
        endcase
      end
      shift_c = {co, r};
    end
  endfunction

  assign advance = busy && !out_full;
  assign in_take = in_valid && (!busy || advance);

  // operands with bypass of the write that landed with the read
  assign a_val = (fwd_valid && fwd_idx == cur.ra) ? fwd_val : rd_a;
  assign b_val = (fwd_valid && fwd_idx == cur.rb) ? fwd_val : rd_b;

  // adder
  assign op_a  = cur.a_inv ? ~a_val : a_val;
  assign b_raw = cur.b_imm ? cur.imm : b_val;
  assign op_b  = cur.b_inv ? ~b_raw : b_raw;
  always_comb begin
    case (cur.cin)
      CIN_ONE:  cin = 1'b1;
      CIN_FLAG: cin = nzcv[1];
      default:  cin = 1'b0;
    endcase
  end
  assign sum   = {1'b0, op_a} + {1'b0, op_b} + {32'd0, cin};
  assign add_v = (op_a[31] ^ sum[31]) & (op_b[31] ^ sum[31]);

  // shifter and multiplier
  assign sh_amt  = cur.amt_reg ? b_val[7:0] : cur.imm[7:0];
  assign sh_out  = shift_c(a_val, cur.sh_type, sh_amt, nzcv[1]);
  assign product = a_val * b_val;

  // result and carry selection
  always_comb begin
    c_out = nzcv[1];
    v_out = nzcv[0];
    case (cur.op)
      OP_ADD: begin
        result = sum[31:0];
        c_out  = sum[32];
        v_out  = add_v;
      end
      OP_SHIFT: begin
        result = sh_out[31:0];
        c_out  = sh_out[32];
      end
      OP_AND:  result = a_val & b_val;
      OP_EOR:  result = a_val ^ b_val;
      OP_ORR:  result = a_val | b_val;
      OP_BIC:  result = a_val & ~b_val;
      OP_MVN:  result = ~b_val;
      OP_MUL:  result = product;
      default: result = b_raw;
    endcase
  end

  // flag update
  always_comb begin
    nzcv_next = nzcv;
    if (cur.fl != FL_NONE) begin
      nzcv_next[3] = result[31];
      nzcv_next[2] = (result == 32'd0);
    end
    if (cur.fl == FL_NZC || cur.fl == FL_NZCV) begin
      nzcv_next[1] = c_out;
    end
    if (cur.fl == FL_NZCV) begin
      nzcv_next[0] = v_out;
    end
  end

  // result item
  assign out_push            = advance;
  assign out_res.dest_index  = cur.wr ? cur.dest : 3'd0;
  assign out_res.dest_value  = cur.wr ? result : 32'd0;
  assign out_res.reg_written = cur.wr;
  assign out_res.flag_n      = nzcv_next[3];
  assign out_res.flag_z      = nzcv_next[2];
  assign out_res.flag_c      = nzcv_next[1];
  assign out_res.flag_v      = nzcv_next[0];
  assign out_res.not_handled = cur.nh;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      fwd_valid <= 1'b0;
      nzcv      <= 4'd0;
      reg_ok    <= 8'd0;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
      end else if (advance) begin
        busy <= 1'b0;
      end
      fwd_valid <= in_take && advance && cur.wr;
      if (advance) begin
        nzcv <= nzcv_next;
      end
      if (advance && cur.wr) begin
        reg_ok[cur.dest] <= 1'b1;
      end
    end
  end

  // register file and operand capture
  always_ff @(posedge clk) begin
    if (advance && cur.wr) begin
      regs[cur.dest] <= result;
    end
    if (in_take) begin
      cur     <= in_uop;
      rd_a    <= reg_ok[in_uop.ra] ? regs[in_uop.ra] : 32'd0;
      rd_b    <= reg_ok[in_uop.rb] ? regs[in_uop.rb] : 32'd0;
      fwd_idx <= cur.dest;
      fwd_val <= result;
    end else begin
      rd_a <= a_val;
      rd_b <= b_val;
    end
  end

  a_fwd_from_commit: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> $past(advance))
    else $error("bypass valid without a commit");
  a_nh_no_effect: assert property (@(posedge clk) disable iff (rst)
    (advance && cur.nh) |-> (!cur.wr && cur.fl == FL_NONE))
    else $error("unhandled item changes state");
  a_written_valid: assert property (@(posedge clk) disable iff (rst)
    (advance && cur.wr) |=> reg_ok[$past(cur.dest)])
    else $error("written register not marked valid");
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(nzcv))
    else $error("flags changed without a commit");

endmodule

// ===== sim/thumb16_alu_execute_tb.sv =====
`timescale 1ns / 1ps

module thumb16_alu_execute_tb;
  import t16alu_pkg::*;

  // item kinds
  localparam logic FN_EXEC = 1'b0;
  localparam logic FN_LOAD = 1'b1;

  // add/sub group opcodes, instruction bits 13:9
  localparam logic [4:0] OPC_ADD_REG = 5'h0C;
  localparam logic [4:0] OPC_SUB_REG = 5'h0D;
  localparam logic [4:0] OPC_ADD_I3  = 5'h0E;
  localparam logic [4:0] OPC_SUB_I3  = 5'h0F;

  // imm8 group, instruction bits 12:11
  localparam logic [1:0] I8_MOV = 2'd0;
  localparam logic [1:0] I8_CMP = 2'd1;
  localparam logic [1:0] I8_ADD = 2'd2;
  localparam logic [1:0] I8_SUB = 2'd3;

  // register alu group, instruction bits 9:6
  localparam logic [3:0] ALU_AND = 4'h0;
  localparam logic [3:0] ALU_EOR = 4'h1;
  localparam logic [3:0] ALU_LSL = 4'h2;
  localparam logic [3:0] ALU_LSR = 4'h3;
  localparam logic [3:0] ALU_ASR = 4'h4;
  localparam logic [3:0] ALU_ADC = 4'h5;
  localparam logic [3:0] ALU_SBC = 4'h6;
  localparam logic [3:0] ALU_ROR = 4'h7;
  localparam logic [3:0] ALU_TST = 4'h8;
  localparam logic [3:0] ALU_RSB = 4'h9;
  localparam logic [3:0] ALU_CMP = 4'hA;
  localparam logic [3:0] ALU_CMN = 4'hB;
  localparam logic [3:0] ALU_ORR = 4'hC;
  localparam logic [3:0] ALU_MUL = 4'hD;
  localparam logic [3:0] ALU_BIC = 4'hE;
  localparam logic [3:0] ALU_MVN = 4'hF;

  localparam logic [15:0] NH_FIRST = 16'h4400;
  localparam int RAND_ITEMS = 1300;
  localparam int CALM_FROM  = 1100;
  localparam int LIMIT      = 200000;

  typedef struct {
    logic        f;
    logic [15:0] ins;
    logic        it;
    logic [2:0]  li;
    logic [31:0] lv;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic        func;
  logic [15:0] instruction;
  logic        in_it_block;
  logic [2:0]  load_index;
  logic [31:0] load_value;
  logic        empty;
  logic        pop;
  logic [2:0]  dest_index;
  logic [31:0] dest_value;
  logic        reg_written;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        flag_v;
  logic        not_handled;

  // mirror of the architectural state
  logic [31:0] gpr [8];
  logic        fn, fz, fc, fv;

  res_t      pending_q [$];
  stim_row_t plan [$];
  int        errors = 0;
  int        cycles = 0;
  int        n_items = 0;
  int        n_loads = 0;
  int        n_nh = 0;
  int        n_it = 0;
  int        n_checked = 0;
  bit        calm = 1'b0;

  thumb16_alu_execute u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .instruction (instruction),
    .in_it_block (in_it_block),
    .load_index  (load_index),
    .load_value  (load_value),
    .empty       (empty),
    .pop         (pop),
    .dest_index  (dest_index),
    .dest_value  (dest_value),
    .reg_written (reg_written),
    .flag_n      (flag_n),
    .flag_z      (flag_z),
    .flag_c      (flag_c),
    .flag_v      (flag_v),
    .not_handled (not_handled)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shifter with carry out, amount 0 keeps the carry
  function automatic logic [31:0] barrel_shift(input logic [31:0] x, input logic [1:0] kind,
                                               input int unsigned amt, input logic cin,
                                               output logic cout);
    logic [31:0] r;
    int unsigned m;
    r = x;
    cout = cin;
    if (amt != 0) begin
      case (kind)
        SH_LSL: begin
          if (amt < 32) begin
            r = x << amt;
            cout = x[32 - amt];
          end else begin
            r = '0;
            cout = (amt == 32) ? x[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (amt < 32) begin
            r = x >> amt;
            cout = x[amt - 1];
          end else begin
            r = '0;
            cout = (amt == 32) ? x[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (amt < 32) begin
            r = $signed(x) >>> amt;
            cout = x[amt - 1];
          end else begin
            r = {32{x[31]}};
            cout = x[31];
          end
        end
        default: begin
          m = amt & 31;
          r = (m == 0) ? x : ((x >> m) | (x << (32 - m)));
          cout = r[31];
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] adc32(input logic [31:0] a, input logic [31:0] b,
                                        input logic cin, output logic cout, output logic ovf);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    cout = s[32];
    ovf = (a[31] ^ s[31]) & (b[31] ^ s[31]);
    return s[31:0];
  endfunction

  // next result of the alu, updates the mirrored registers and flags
  function automatic res_t predict_alu(input logic f, input logic [15:0] ins, input logic it,
                                       input logic [2:0] li, input logic [31:0] lv);
    res_t        r;
    logic [4:0]  opc;
    logic [1:0]  kind;
    logic [31:0] a, b, rn, rm, imm, val;
    logic [2:0]  d;
    logic        cy, ov, wr, nh, forced;
    int unsigned amt;
    fl_t         fl;
    d = '0;
    val = '0;
    wr = 1'b0;
    nh = 1'b0;
    cy = 1'b0;
    ov = 1'b0;
    forced = 1'b0;
    fl = FL_NONE;
    if (f == FN_LOAD) begin
      d = li;
      val = lv;
      wr = 1'b1;
    end else if (ins[15:10] < 6'h10) begin
      opc = ins[13:9];
      if (opc < OPC_ADD_REG) begin
        // shift by immediate, lsr/asr by 0 mean 32
        kind = ins[12:11];
        amt = 32'(ins[10:6]);
        if (kind != SH_LSL && amt == 0) amt = 32;
        d = ins[2:0];
        val = barrel_shift(gpr[ins[5:3]], kind, amt, fc, cy);
        wr = 1'b1;
        fl = FL_NZC;
      end else if (opc <= OPC_SUB_I3) begin
        a = gpr[ins[5:3]];
        b = (opc <= OPC_SUB_REG) ? gpr[ins[8:6]] : {29'd0, ins[8:6]};
        d = ins[2:0];
        if (opc == OPC_ADD_REG || opc == OPC_ADD_I3) val = adc32(a, b, 1'b0, cy, ov);
        else val = adc32(a, ~b, 1'b1, cy, ov);
        wr = 1'b1;
        fl = FL_NZCV;
      end else begin
        d = ins[10:8];
        imm = {24'd0, ins[7:0]};
        fl = FL_NZCV;
        wr = 1'b1;
        case (ins[12:11])
          I8_MOV: begin
            val = imm;
            fl = FL_NZ;
          end
          I8_CMP: begin
            val = adc32(gpr[d], ~imm, 1'b1, cy, ov);
            wr = 1'b0;
            forced = 1'b1;
          end
          I8_ADD: val = adc32(gpr[d], imm, 1'b0, cy, ov);
          default: val = adc32(gpr[d], ~imm, 1'b1, cy, ov);
        endcase
      end
    end else if (ins[15:10] == 6'h10) begin
      rn = gpr[ins[2:0]];
      rm = gpr[ins[5:3]];
      amt = 32'(rm[7:0]);
      d = ins[2:0];
      wr = 1'b1;
      fl = FL_NZC;
      cy = fc;
      case (ins[9:6])
        ALU_AND: val = rn & rm;
        ALU_EOR: val = rn ^ rm;
        ALU_LSL: val = barrel_shift(rn, SH_LSL, amt, fc, cy);
        ALU_LSR: val = barrel_shift(rn, SH_LSR, amt, fc, cy);
        ALU_ASR: val = barrel_shift(rn, SH_ASR, amt, fc, cy);
        ALU_ADC: begin
          val = adc32(rn, rm, fc, cy, ov);
          fl = FL_NZCV;
        end
        ALU_SBC: begin
          val = adc32(rn, ~rm, fc, cy, ov);
          fl = FL_NZCV;
        end
        ALU_ROR: val = barrel_shift(rn, SH_ROR, amt, fc, cy);
        ALU_TST: begin
          val = rn & rm;
          wr = 1'b0;
          forced = 1'b1;
        end
        ALU_RSB: begin
          val = adc32(~rn, 32'd0, 1'b1, cy, ov);
          fl = FL_NZCV;
        end
        ALU_CMP: begin
          val = adc32(rn, ~rm, 1'b1, cy, ov);
          fl = FL_NZCV;
          wr = 1'b0;
          forced = 1'b1;
        end
        ALU_CMN: begin
          val = adc32(rn, rm, 1'b0, cy, ov);
          fl = FL_NZCV;
          wr = 1'b0;
          forced = 1'b1;
        end
        ALU_ORR: val = rn | rm;
        ALU_MUL: begin
          val = rn * rm;
          fl = FL_NZ;
        end
        ALU_BIC: val = rn & ~rm;
        default: val = ~rm;
      endcase
    end else begin
      nh = 1'b1;
    end
    // flag update, inside an it block only compares and tests write
    if (fl != FL_NONE && (forced || !it)) begin
      fn = val[31];
      fz = (val == 32'd0);
      if (fl == FL_NZC || fl == FL_NZCV) fc = cy;
      if (fl == FL_NZCV) fv = ov;
    end
    if (wr) begin
      gpr[d] = val;
    end else begin
      d = '0;
      val = '0;
    end
    r.dest_index = d;
    r.dest_value = val;
    r.reg_written = wr;
    r.flag_n = fn;
    r.flag_z = fz;
    r.flag_c = fc;
    r.flag_v = fv;
    r.not_handled = nh;
    return r;
  endfunction

  // instruction encoders for the directed table
  function automatic logic [15:0] f_shift(input logic [1:0] kind, input logic [4:0] imm5,
                                          input logic [2:0] rm, input logic [2:0] rd);
    return {3'b000, kind, imm5, rm, rd};
  endfunction

  function automatic logic [15:0] f_add3(input logic [4:0] opc, input logic [2:0] rm,
                                         input logic [2:0] rn, input logic [2:0] rd);
    return {2'b00, opc, rm, rn, rd};
  endfunction

  function automatic logic [15:0] f_imm8(input logic [1:0] sel, input logic [2:0] rd,
                                         input logic [7:0] imm);
    return {3'b001, sel, rd, imm};
  endfunction

  function automatic logic [15:0] f_alu(input logic [3:0] op, input logic [2:0] rm,
                                        input logic [2:0] rdn);
    return {6'b010000, op, rm, rdn};
  endfunction

  task automatic add_row(input logic f, input logic [15:0] ins, input logic it,
                         input logic [2:0] li, input logic [31:0] lv, input bit typed,
                         input res_t want);
    stim_row_t row;
    row.f = f;
    row.ins = ins;
    row.it = it;
    row.li = li;
    row.lv = lv;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  // drive one item from a falling edge, hold until taken, record what it should give
  task automatic send_item(input logic f, input logic [15:0] ins, input logic it,
                           input logic [2:0] li, input logic [31:0] lv, input bit typed,
                           input res_t want);
    res_t guess;
    push = 1'b1;
    func = f;
    instruction = ins;
    in_it_block = it;
    load_index = li;
    load_value = lv;
    @(posedge clk);
    while (full) @(posedge clk);
    guess = predict_alu(f, ins, it, li, lv);
    pending_q.push_back(typed ? want : guess);
    n_items++;
    if (f == FN_LOAD) n_loads++;
    else if (ins >= NH_FIRST) n_nh++;
    else if (it) n_it++;
    @(negedge clk);
  endtask

  // random gap on the sending side
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 9) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result side: compare every popped item with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none actual dest %0h value %0h", $time,
                 dest_index, dest_value);
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        check_field("dest_index", 32'(want.dest_index), 32'(dest_index));
        check_field("dest_value", want.dest_value, dest_value);
        check_field("reg_written", 32'(want.reg_written), 32'(reg_written));
        check_field("flag_n", 32'(want.flag_n), 32'(flag_n));
        check_field("flag_z", 32'(want.flag_z), 32'(flag_z));
        check_field("flag_c", 32'(want.flag_c), 32'(flag_c));
        check_field("flag_v", 32'(want.flag_v), 32'(flag_v));
        check_field("not_handled", 32'(want.not_handled), 32'(not_handled));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts, none near the end
  initial begin
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        pop = 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] w, lv;
    logic [15:0] ins;
    logic        f, it;
    int          pick;
    rst = 1'b1;
    push = 1'b0;
    func = FN_EXEC;
    instruction = '0;
    in_it_block = 1'b0;
    load_index = '0;
    load_value = '0;
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    {fn, fz, fc, fv} = 4'b0000;

    // directed table: reset values, loads, unhandled range, every encoding group and op
    add_row(FN_EXEC, f_imm8(I8_MOV, 3'd0, 8'h00), 1'b0, 3'd0, 32'd0, 1'b1,
            {3'd0, 32'd0, 1'b1, 4'b0100, 1'b0});
    add_row(FN_LOAD, 16'hFFFF, 1'b1, 3'd1, 32'hFFFF_FFFF, 1'b1,
            {3'd1, 32'hFFFF_FFFF, 1'b1, 4'b0100, 1'b0});
    add_row(FN_LOAD, 16'h0000, 1'b0, 3'd2, 32'h8000_0000, 1'b1,
            {3'd2, 32'h8000_0000, 1'b1, 4'b0100, 1'b0});
    add_row(FN_EXEC, NH_FIRST, 1'b0, 3'd7, 32'hFFFF_FFFF, 1'b1,
            {3'd0, 32'd0, 1'b0, 4'b0100, 1'b1});
    add_row(FN_EXEC, 16'hFFFF, 1'b1, 3'd5, 32'd0, 1'b1,
            {3'd0, 32'd0, 1'b0, 4'b0100, 1'b1});
    add_row(FN_EXEC, f_shift(SH_LSL, 5'd31, 3'd1, 3'd5), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_shift(SH_LSR, 5'd0, 3'd2, 3'd5), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_shift(SH_ASR, 5'd0, 3'd2, 3'd6), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_add3(OPC_ADD_REG, 3'd0, 3'd1, 3'd4), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_add3(OPC_SUB_REG, 3'd1, 3'd2, 3'd7), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_add3(OPC_ADD_I3, 3'd7, 3'd1, 3'd3), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_add3(OPC_SUB_I3, 3'd1, 3'd2, 3'd0), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_imm8(I8_CMP, 3'd1, 8'hFF), 1'b1, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_imm8(I8_ADD, 3'd0, 8'hFF), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_imm8(I8_SUB, 3'd3, 8'hFF), 1'b1, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_AND, 3'd2, 3'd1), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_EOR, 3'd1, 3'd4), 1'b1, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_LSL, 3'd6, 3'd3), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_LSR, 3'd3, 3'd6), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_ASR, 3'd0, 3'd2), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_ADC, 3'd6, 3'd2), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_SBC, 3'd2, 3'd5), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_ROR, 3'd0, 3'd7), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_TST, 3'd7, 3'd6), 1'b1, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_RSB, 3'd4, 3'd3), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_CMP, 3'd1, 3'd2), 1'b1, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_CMN, 3'd6, 3'd6), 1'b1, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_ORR, 3'd5, 3'd0), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_MUL, 3'd1, 3'd7), 1'b0, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_BIC, 3'd2, 3'd4), 1'b1, 3'd0, 32'd0, 1'b0, '0);
    add_row(FN_EXEC, f_alu(ALU_MVN, 3'd0, 3'd5), 1'b0, 3'd0, 32'd0, 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      maybe_gap();
      send_item(plan[i].f, plan[i].ins, plan[i].it, plan[i].li, plan[i].lv, plan[i].typed,
                plan[i].want);
    end

    // random part: loads with shift-friendly values, each encoding group equally likely
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == CALM_FROM) calm = 1'b1;
      w = $urandom;
      it = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: lv = 32'd0;
        1: lv = 32'hFFFF_FFFF;
        2: lv = 32'h8000_0000 | $urandom_range(0, 3);
        3: lv = $urandom_range(0, 40);
        4: lv = {24'($urandom_range(0, 255)), 8'(256 - $urandom_range(1, 20))};
        default: lv = $urandom;
      endcase
      if (pick < 18) begin
        f = FN_LOAD;
        ins = w[31:16];
      end else if (pick < 26) begin
        f = FN_EXEC;
        ins = 16'($urandom_range(NH_FIRST, 16'hFFFF));
      end else begin
        f = FN_EXEC;
        case ($urandom_range(0, 3))
          0: ins = {3'b000, 2'($urandom_range(0, 2)), w[10:0]};
          1: ins = {2'b00, 3'b011, w[10:0]};
          2: ins = {3'b001, w[12:0]};
          default: ins = {6'b010000, w[9:0]};
        endcase
      end
      maybe_gap();
      send_item(f, ins, it, 3'($urandom_range(0, 7)), lv, 1'b0, '0);
    end
    push = 1'b0;

    // drain and let the pipeline settle
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d items: %0d loads, %0d unhandled encodings, %0d inside it blocks",
             n_items, n_loads, n_nh, n_it);
    $display("checked %0d results field by field, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/t16alu_pkg.sv
rtl/t16alu_fifo.sv
rtl/t16alu_decode.sv
rtl/t16alu_exec.sv
rtl/thumb16_alu_execute.sv
sim/thumb16_alu_execute_tb.sv
